### rtl/hpw_pkg.sv
// hpw_pkg: shared constants for the homography point warp
// no dependencies
package hpw_pkg;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 60;
  localparam logic [CfgIdxBits-1:0] RegRow0 = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegRow1 = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegRow2 = 2'd2;
endpackage

### rtl/homography_point_warp.sv
// homography_point_warp: translate, project through a 3x3 homography, divide
// accepts one request per cycle whenever the output register is empty or being taken.
// each result passes, in order, through three front stages (add, multiply, sum),
// then one division cell per quotient bit with the x and y quotients in two lanes
// side by side, then the saturation and output register. the division chain sets
// the latency. the whole pipeline stalls while a result waits unaccepted in the
// output register
module homography_point_warp #(
  parameter int unsigned COORD_BITS = 20,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x_in, y_in, x_shift, y_shift from bit 0 up
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // x_out, y_out, divisor_zero, clipped from bit 0 up
  output logic [((2*COORD_BITS+2+7)/8)*8-1:0]   m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [hpw_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  logic [3*COORD_BITS-1:0]               cfg_data_i
);
  import hpw_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned PB = CB + 1;            // translated point
  localparam int unsigned MB = CB + PB;           // one product
  localparam int unsigned SB = MB + 2;            // sum of three
  localparam int unsigned NB = SB - 1 + FRAC_BITS; // magnitude numerator
  localparam int unsigned DB = SB;                // magnitude divisor
  localparam int unsigned OB = ((2*CB+2+7)/8)*8;

  logic [3*CB-1:0] row0_q, row1_q, row2_q;
  logic en;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= (3*CB)'(1) << FRAC_BITS;
      row1_q <= (3*CB)'(1) << (FRAC_BITS + CB);
      row2_q <= (3*CB)'(1) << (FRAC_BITS + 2*CB);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRow0: row0_q <= cfg_data_i;
        RegRow1: row1_q <= cfg_data_i;
        RegRow2: row2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic out_v_q;
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: translate
  logic v1_q;
  logic signed [PB-1:0] px_q, py_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= PB'(signed'(s_axis_tdata[CB-1:0])) + PB'(signed'(s_axis_tdata[3*CB-1:2*CB]));
      py_q <= PB'(signed'(s_axis_tdata[2*CB-1:CB])) + PB'(signed'(s_axis_tdata[4*CB-1:3*CB]));
    end
  end

  // stage 2: products
  logic v2_q;
  logic signed [MB-1:0] pa_q [3];
  logic signed [MB-1:0] pb_q [3];
  logic signed [MB-1:0] pc_q [3];
  logic [3*CB-1:0] rows [3];
  assign rows[0] = row0_q;
  assign rows[1] = row1_q;
  assign rows[2] = row2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  for (genvar k = 0; k < 3; k++) begin : g_row
    logic signed [CB-1:0] c0, c1, c2;
    assign c0 = rows[k][CB-1:0];
    assign c1 = rows[k][2*CB-1:CB];
    assign c2 = rows[k][3*CB-1:2*CB];
    always_ff @(posedge clk_i) begin
      if (en) begin
        pa_q[k] <= MB'(c0) * MB'(px_q);
        pb_q[k] <= MB'(c1) * MB'(py_q);
        pc_q[k] <= MB'(c2) <<< FRAC_BITS;
      end
    end
  end

  // stage 3: sums, signs and magnitudes
  logic signed [SB-1:0] sum [3];
  for (genvar k = 0; k < 3; k++) begin : g_sum
    assign sum[k] = SB'(pa_q[k]) + SB'(pb_q[k]) + SB'(pc_q[k]);
  end
  logic [DB-1:0] wmag, nxmag, nymag;
  assign wmag = sum[2][SB-1] ? DB'(-sum[2]) : DB'(sum[2]);
  assign nxmag = sum[0][SB-1] ? DB'(-sum[0]) : DB'(sum[0]);
  assign nymag = sum[1][SB-1] ? DB'(-sum[1]) : DB'(sum[1]);

  logic v3_q, zero_q, negx_q, negy_q;
  logic [NB-1:0] numx_q, numy_q;
  logic [DB-1:0] den_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q <= (sum[2] == '0);
      negx_q <= sum[0][SB-1] ^ sum[2][SB-1];
      negy_q <= sum[1][SB-1] ^ sum[2][SB-1];
      numx_q <= NB'(nxmag) << FRAC_BITS;
      numy_q <= NB'(nymag) << FRAC_BITS;
      den_q <= wmag;
    end
  end

  // division lanes
  logic vx, vy;
  logic [NB-1:0] qx, qy;
  logic [1:0] sx;
  logic [0:0] sy;
  hpw_div_chain #(.RemBits(DB), .NumBits(NB), .SideBits(2)) u_divx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .num_i(numx_q), .den_i(den_q),
    .side_i({zero_q, negx_q}),
    .valid_o(vx), .quo_o(qx), .side_o(sx)
  );
  hpw_div_chain #(.RemBits(DB), .NumBits(NB), .SideBits(1)) u_divy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .num_i(numy_q), .den_i(den_q),
    .side_i(negy_q),
    .valid_o(vy), .quo_o(qy), .side_o(sy)
  );

  // saturation and output register
  function automatic logic [CB:0] sat(input logic [NB-1:0] q, input logic neg);
    logic [NB-1:0] lim;
    logic [CB-1:0] v;
    logic c;
    lim = (NB'(1) << (CB-1)) - NB'(!neg);
    c = q > lim;
    v = c ? lim[CB-1:0] : q[CB-1:0];
    if (neg) v = -v;
    return {c, v};
  endfunction

  logic [CB:0] rx, ry;
  assign rx = sat(qx, sx[0]);
  assign ry = sat(qy, sy[0]);

  logic [OB-1:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= vx & vy;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sx[1]) begin
        out_q <= OB'({1'b0, 1'b1, {CB{1'b0}}, {CB{1'b0}}});
      end else begin
        out_q <= OB'({rx[CB] | ry[CB], 1'b0, ry[CB-1:0], rx[CB-1:0]});
      end
    end
  end
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;
endmodule

### rtl/hpw_div_cell.sv
// hpw_div_cell: one restoring-division step of the quotient chain
// depends on nothing; chained by hpw_div_chain
module hpw_div_cell #(
  parameter int unsigned RemBits = 48,
  parameter int unsigned NumBits = 64,
  parameter int unsigned SideBits = 50
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [RemBits-1:0]  rem_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [RemBits-1:0]  den_i,
  input  logic [NumBits-1:0]  quo_i,
  input  logic [SideBits-1:0] side_i,
  output logic                valid_o,
  output logic [RemBits-1:0]  rem_o,
  output logic [NumBits-1:0]  num_o,
  output logic [RemBits-1:0]  den_o,
  output logic [NumBits-1:0]  quo_o,
  output logic [SideBits-1:0] side_o
);
  logic [RemBits:0] trial;
  logic [RemBits:0] diff;
  assign trial = {rem_i, num_i[NumBits-1]};
  assign diff = trial - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!diff[RemBits]) begin
        rem_o <= diff[RemBits-1:0];
      end else begin
        rem_o <= trial[RemBits-1:0];
      end
      quo_o <= {quo_i[NumBits-2:0], ~diff[RemBits]};
      num_o <= {num_i[NumBits-2:0], 1'b0};
      den_o <= den_i;
      side_o <= side_i;
    end
  end
endmodule

### rtl/hpw_div_chain.sv
// hpw_div_chain: a row of division cells, one quotient bit per cell
// depends on hpw_div_cell
module hpw_div_chain #(
  parameter int unsigned RemBits = 48,
  parameter int unsigned NumBits = 64,
  parameter int unsigned SideBits = 50
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [RemBits-1:0]  den_i,
  input  logic [SideBits-1:0] side_i,
  output logic                valid_o,
  output logic [NumBits-1:0]  quo_o,
  output logic [SideBits-1:0] side_o
);
  logic                v   [NumBits+1];
  logic [RemBits-1:0]  r   [NumBits+1];
  logic [NumBits-1:0]  n   [NumBits+1];
  logic [RemBits-1:0]  d   [NumBits+1];
  logic [NumBits-1:0]  q   [NumBits+1];
  logic [SideBits-1:0] s   [NumBits+1];

  assign v[0] = valid_i;
  assign r[0] = '0;
  assign n[0] = num_i;
  assign d[0] = den_i;
  assign q[0] = '0;
  assign s[0] = side_i;

  for (genvar g = 0; g < NumBits; g++) begin : g_cell
    hpw_div_cell #(.RemBits(RemBits), .NumBits(NumBits), .SideBits(SideBits)) u_cell (
      .clk_i, .rst_ni, .en_i,
      .valid_i(v[g]), .rem_i(r[g]), .num_i(n[g]), .den_i(d[g]), .quo_i(q[g]),
      .side_i(s[g]),
      .valid_o(v[g+1]), .rem_o(r[g+1]), .num_o(n[g+1]), .den_o(d[g+1]),
      .quo_o(q[g+1]), .side_o(s[g+1])
    );
  end

  assign valid_o = v[NumBits];
  assign quo_o = q[NumBits];
  assign side_o = s[NumBits];
endmodule
